[rtl/core/ps2_mouse_packet_cursor_macros.svh]
// Assertion macros for the PS/2 mouse packet cursor block.
`ifndef PS2_MOUSE_PACKET_CURSOR_MACROS_SVH
`define PS2_MOUSE_PACKET_CURSOR_MACROS_SVH

`ifndef SYNTH
// Check that the consequent holds in the same cycle as the antecedent.
`define PMC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ps2 mouse cursor check failed");
// Check that the consequent holds in the cycle after the antecedent.
`define PMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ps2 mouse cursor check failed");
`else
`define PMC_ASSERT_SAME(label, clk, rst, ante, cons)
`define PMC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[rtl/core/ps2mpc_pkg.sv]
// Shared constants for the PS/2 mouse packet cursor block.
package ps2mpc_pkg;

   // Cursor coordinate width default
   localparam int COORD_BITS_DEF = 12;

   // Register widths
   localparam int SIZE_W = 13;
   localparam int CSR_IDX_W = 2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MOUSE_ENABLED = 2'd2;

   // Register reset values
   localparam logic [SIZE_W-1:0] RST_SCREEN_WIDTH  = 13'd640;
   localparam logic [SIZE_W-1:0] RST_SCREEN_HEIGHT = 13'd480;
   localparam int RST_CURSOR_X = 320;
   localparam int RST_CURSOR_Y = 240;

   // Controller status bits
   localparam int ST_OUT_FULL_BIT = 0;
   localparam int ST_AUX_BIT      = 5;

   // Packet first-byte bits
   localparam int PK_SYNC_BIT  = 3;
   localparam int PK_XSIGN_BIT = 4;
   localparam int PK_YSIGN_BIT = 5;
   localparam logic [7:0] PK_OVF_MASK = 8'hC0;
   localparam logic [7:0] PK_BUTTONS_MASK = 8'h07;

   // Packet byte position codes
   localparam logic [1:0] BYTE_FIRST  = 2'd0;
   localparam logic [1:0] BYTE_SECOND = 2'd1;
   localparam logic [1:0] BYTE_THIRD  = 2'd2;

endpackage

[rtl/core/ps2_mouse_packet_cursor.sv]
// PS/2 mouse packet decoder that moves a clamped screen cursor.
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | status byte, data byte
//  rsp     | out       | rsp_valid/rsp_stall | cursor, deltas, buttons, sequence
//  csr     | in        | csr_write_en        | index, 13-bit write data
//
// A request is taken every cycle the input register is free or drains; it is
// decoded while it sits in the input register, and its result (if any) is
// registered when it retires; throughput is one request per cycle unless stalled.
// The input register drains whenever the result register is empty or taken.
// Synchronous reset puts the screen at 640x480, the cursor at its center,
// the mouse disabled and the packet gatherer at the first byte.
`include "ps2_mouse_packet_cursor_macros.svh"

module ps2_mouse_packet_cursor
   import ps2mpc_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_status_byte,
   input  logic [7:0]            req_data_byte,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [COORD_BITS-1:0] rsp_cursor_x,
   output logic [COORD_BITS-1:0] rsp_cursor_y,
   output logic signed [8:0]     rsp_delta_x,
   output logic signed [9:0]     rsp_delta_y,
   output logic [2:0]            rsp_buttons,
   output logic [31:0]           rsp_sequence_res,
   // configuration port
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [SIZE_W-1:0]     csr_wdata
);

   localparam int CB = COORD_BITS;
   localparam int SUM_W = CB + 2;
   localparam int CAP_W = (CB + 1 > SIZE_W) ? CB + 1 : SIZE_W;
   localparam int CMAX = (1 << CB) - 1;
   localparam int CUR_X_RST = (RST_CURSOR_X < CMAX) ? RST_CURSOR_X : CMAX;
   localparam int CUR_Y_RST = (RST_CURSOR_Y < CMAX) ? RST_CURSOR_Y : CMAX;

   // Move a position by a delta and clamp it into [0, min(max(size,1), 2^CB) - 1].
   function automatic logic [CB-1:0] clamp_move(input logic [CB-1:0] pos,
                                                input logic signed [9:0] delta,
                                                input logic [SIZE_W-1:0] size);
      logic signed [SUM_W-1:0] sum;
      logic [CB-1:0] lim_m1;
      logic [CAP_W-1:0] size_ext;
      logic [CAP_W-1:0] cap;
      logic [CB-1:0] res;
      size_ext = CAP_W'(size);
      cap = CAP_W'(1) << CB;
      if (size == '0) begin
         lim_m1 = '0;
      end else if (size_ext > cap) begin
         lim_m1 = '1;
      end else begin
         lim_m1 = CB'(size_ext - CAP_W'(1));
      end
      sum = $signed({2'b00, pos}) + SUM_W'(delta);
      if (sum < 0) begin
         res = '0;
      end else if (sum > $signed({2'b00, lim_m1})) begin
         res = lim_m1;
      end else begin
         res = sum[CB-1:0];
      end
      return res;
   endfunction

   // Configuration registers
   logic [SIZE_W-1:0] scr_w_ff;
   logic [SIZE_W-1:0] scr_h_ff;
   logic              mouse_en_ff;

   // Input register
   logic       in_vld_ff;
   logic       in_vld_in;
   logic [7:0] in_status_ff;
   logic [7:0] in_data_ff;

   // Packet and cursor state
   logic [1:0]    byte_idx_ff;
   logic [1:0]    byte_idx_in;
   logic [7:0]    first_ff;
   logic [7:0]    first_in;
   logic [7:0]    second_ff;
   logic [7:0]    second_in;
   logic [CB-1:0] cur_x_ff;
   logic [CB-1:0] cur_x_in;
   logic [CB-1:0] cur_y_ff;
   logic [CB-1:0] cur_y_in;
   logic [31:0]   pkt_cnt_ff;
   logic [31:0]   pkt_cnt_in;

   // Result register
   logic        rsp_vld_ff;
   logic        rsp_vld_in;
   logic [CB-1:0] rsp_x_ff;
   logic [CB-1:0] rsp_y_ff;
   logic signed [8:0] rsp_dx_ff;
   logic signed [9:0] rsp_dy_ff;
   logic [2:0]  rsp_btn_ff;
   logic [31:0] rsp_seq_ff;

   // Decode signals
   logic              out_free;
   logic              retire;
   logic              byte_ok;
   logic              produce;
   logic signed [8:0] dx;
   logic signed [9:0] dy_neg;
   logic signed [9:0] dx_ext;
   logic [CB-1:0]     new_x;
   logic [CB-1:0]     new_y;

   assign out_free  = !rsp_vld_ff || !rsp_stall;
   assign retire    = in_vld_ff && out_free;
   assign req_stall = in_vld_ff && !out_free;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scr_w_ff    <= RST_SCREEN_WIDTH;
         scr_h_ff    <= RST_SCREEN_HEIGHT;
         mouse_en_ff <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  scr_w_ff <= csr_wdata;
            CSR_SCREEN_HEIGHT: scr_h_ff <= csr_wdata;
            CSR_MOUSE_ENABLED: mouse_en_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Capture request into the input register
   assign in_vld_in = (req_valid && !req_stall) || (in_vld_ff && !retire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_status_ff <= req_status_byte;
         in_data_ff   <= req_data_byte;
      end
   end

   // Decode the byte in the input register
   assign byte_ok = in_status_ff[ST_OUT_FULL_BIT] && in_status_ff[ST_AUX_BIT] && mouse_en_ff;
   assign dx      = $signed({first_ff[PK_XSIGN_BIT], second_ff});
   assign dy_neg  = -$signed({first_ff[PK_YSIGN_BIT], first_ff[PK_YSIGN_BIT], in_data_ff});
   assign dx_ext  = 10'(dx);
   assign new_x   = clamp_move(cur_x_ff, dx_ext, scr_w_ff);
   assign new_y   = clamp_move(cur_y_ff, dy_neg, scr_h_ff);

   always_comb begin
      byte_idx_in = byte_idx_ff;
      first_in    = first_ff;
      second_in   = second_ff;
      cur_x_in    = cur_x_ff;
      cur_y_in    = cur_y_ff;
      pkt_cnt_in  = pkt_cnt_ff;
      produce     = 1'b0;
      if (retire && byte_ok) begin
         case (byte_idx_ff)
            BYTE_FIRST: begin
               // drop a byte that cannot open a packet
               if (in_data_ff[PK_SYNC_BIT]) begin
                  first_in    = in_data_ff;
                  byte_idx_in = BYTE_SECOND;
               end
            end
            BYTE_SECOND: begin
               second_in   = in_data_ff;
               byte_idx_in = BYTE_THIRD;
            end
            BYTE_THIRD: begin
               byte_idx_in = BYTE_FIRST;
               // drop packets with an overflow flag
               if ((first_ff & PK_OVF_MASK) == 8'h00) begin
                  cur_x_in   = new_x;
                  cur_y_in   = new_y;
                  pkt_cnt_in = pkt_cnt_ff + 32'd1;
                  produce    = 1'b1;
               end
            end
            default: begin
               byte_idx_in = BYTE_FIRST;
            end
         endcase
      end
   end

   // Advance packet and cursor state
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_idx_ff <= BYTE_FIRST;
         first_ff    <= 8'h00;
         second_ff   <= 8'h00;
         cur_x_ff    <= CB'(CUR_X_RST);
         cur_y_ff    <= CB'(CUR_Y_RST);
         pkt_cnt_ff  <= 32'd0;
      end else begin
         byte_idx_ff <= byte_idx_in;
         first_ff    <= first_in;
         second_ff   <= second_in;
         cur_x_ff    <= cur_x_in;
         cur_y_ff    <= cur_y_in;
         pkt_cnt_ff  <= pkt_cnt_in;
      end
   end

   // Load the result register
   assign rsp_vld_in = out_free ? produce : rsp_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         rsp_x_ff   <= new_x;
         rsp_y_ff   <= new_y;
         rsp_dx_ff  <= dx;
         rsp_dy_ff  <= dy_neg;
         rsp_btn_ff <= first_ff[2:0] & PK_BUTTONS_MASK[2:0];
         rsp_seq_ff <= pkt_cnt_in;
      end
   end

   assign rsp_valid        = rsp_vld_ff;
   assign rsp_cursor_x     = rsp_x_ff;
   assign rsp_cursor_y     = rsp_y_ff;
   assign rsp_delta_x      = rsp_dx_ff;
   assign rsp_delta_y      = rsp_dy_ff;
   assign rsp_buttons      = rsp_btn_ff;
   assign rsp_sequence_res = rsp_seq_ff;

   // Pending result always matches the live cursor and count
   `PMC_ASSERT_SAME(a_rsp_count, clock, reset, rsp_vld_ff, rsp_seq_ff == pkt_cnt_ff)
   `PMC_ASSERT_SAME(a_rsp_cursor, clock, reset, rsp_vld_ff, (rsp_x_ff == cur_x_ff) && (rsp_y_ff == cur_y_ff))
   // A disabled mouse never yields a result
   `PMC_ASSERT_NEXT(a_disabled, clock, reset, retire && !mouse_en_ff, !rsp_vld_ff)
   // Back-pressure only while both registers are full
   `PMC_ASSERT_SAME(a_stall_full, clock, reset, req_stall, in_vld_ff && rsp_vld_ff && rsp_stall)

endmodule
